// File: rtl/mtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_pkg
// Shared types and constants of the model transform matrix block.
// ----------------------------------------------------------------------------
package mtm_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_ITERS_DEF = 16;

  localparam logic [16:0] MOVE_STEP_RST = 17'd6554;
  localparam logic [14:0] TURN_STEP_RST = 15'd522;
  localparam logic [16:0] GROW_STEP_RST = 17'd6554;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [2:0] {
    ACT_RESET  = 3'd0,
    ACT_MOVE   = 3'd1,
    ACT_ROTATE = 3'd2,
    ACT_SCALE  = 3'd3,
    ACT_EMIT   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    REG_MOVE = 2'd0,
    REG_TURN = 2'd1,
    REG_GROW = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_PROD,
    ST_ELEM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] axis;
    logic       upward;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               last;
  } out_item_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/model_transform_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// model_transform_matrix
// Keeps position, rotation and scale; emits the 4x4 model matrix per event.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one event transaction (action, axis,
//   upward). After the state update the block runs three CORDIC passes on a
//   shared shift-add unit, then forms the rotation terms on one shared
//   multiplier, one product per cycle.
//   The 16 elements follow row-major on out_valid/out_ready/out_data; the
//   rotation elements are scaled by the same multiplier as they enter the
//   output register, and last is set on the sixteenth.
//   The output register takes the next element only after the current one
//   has been taken. One event is in work at a time; in_ready is high only
//   while idle. A stalled receiver holds the current element in the output
//   register and so lengthens the event.
//   Reset clears position and angles, sets scale to 1.0 and loads the step
//   registers with their defaults. The cfg_ APB port writes and reads the
//   step registers at byte addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module model_transform_matrix #(
  parameter int FRAC_BITS    = mtm_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS   = mtm_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_ITERS = mtm_pkg::CORDIC_ITERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mtm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mtm_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam logic signed [32:0] ONE_FX = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [32:0] SCALE_FLOOR =
    33'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam int IT_W = $clog2(CORDIC_ITERS);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_ITERS - 1);

  // configuration
  logic [16:0] move_step_r;
  logic [14:0] turn_step_r;
  logic [16:0] grow_step_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_step_r <= mtm_pkg::MOVE_STEP_RST;
      turn_step_r <= mtm_pkg::TURN_STEP_RST;
      grow_step_r <= mtm_pkg::GROW_STEP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mtm_pkg::REG_MOVE: move_step_r <= cfg_pwdata[16:0];
        mtm_pkg::REG_TURN: turn_step_r <= cfg_pwdata[14:0];
        mtm_pkg::REG_GROW: grow_step_r <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mtm_pkg::REG_MOVE: cfg_prdata = {15'd0, move_step_r};
      mtm_pkg::REG_TURN: cfg_prdata = {17'd0, turn_step_r};
      mtm_pkg::REG_GROW: cfg_prdata = {15'd0, grow_step_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // pose state
  logic signed [31:0]   offset_r  [3];
  logic [ANGLE_BITS-1:0] angle_r  [3];
  logic signed [31:0]   stretch_r [3];

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647)       return 32'sh7fffffff;
    else if (v < -33'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        offset_r[i]  <= '0;
        angle_r[i]   <= '0;
        stretch_r[i] <= ONE_FX[31:0];
      end
    end else if (in_acc) begin
      if (in_data.action == mtm_pkg::ACT_RESET) begin
        for (int i = 0; i < 3; i++) begin
          offset_r[i]  <= '0;
          angle_r[i]   <= '0;
          stretch_r[i] <= ONE_FX[31:0];
        end
      end else if (in_data.axis != 2'd3) begin
        priority case (in_data.action)
          mtm_pkg::ACT_MOVE: offset_r[in_data.axis] <= sat33(in_data.upward ?
            33'(offset_r[in_data.axis]) + 33'(move_step_r) :
            33'(offset_r[in_data.axis]) - 33'(move_step_r));
          mtm_pkg::ACT_ROTATE: angle_r[in_data.axis] <= in_data.upward ?
            angle_r[in_data.axis] + ANGLE_BITS'(turn_step_r) :
            angle_r[in_data.axis] - ANGLE_BITS'(turn_step_r);
          mtm_pkg::ACT_SCALE: begin
            logic signed [31:0] sv;
            sv = sat33(in_data.upward ?
              33'(stretch_r[in_data.axis]) + 33'(grow_step_r) :
              33'(stretch_r[in_data.axis]) - 33'(grow_step_r));
            stretch_r[in_data.axis] <= (33'(sv) < SCALE_FLOOR) ?
              SCALE_FLOOR[31:0] : sv;
          end
          default: ;
        endcase
      end
    end
  end

  // sequencer
  mtm_pkg::state_t state_r, state_nxt;
  logic [IT_W-1:0] it_r, it_nxt;
  logic [1:0]      ax_r, ax_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic            emit_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtm_pkg::ST_IDLE;
      it_r    <= '0;
      ax_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      it_r    <= it_nxt;
      ax_r    <= ax_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready  = (state_r == mtm_pkg::ST_IDLE);
  assign emit_done = out_valid && out_ready && out_data.last;

  always_comb begin
    state_nxt = state_r;
    it_nxt    = it_r;
    ax_nxt    = ax_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      mtm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = mtm_pkg::ST_TRIG;
          it_nxt    = '0;
          ax_nxt    = 2'd0;
        end
      end
      mtm_pkg::ST_TRIG: begin
        it_nxt = it_r + 1'b1;
        if (it_r == IT_LAST) begin
          it_nxt = '0;
          ax_nxt = ax_r + 2'd1;
          if (ax_r == 2'd2) begin
            state_nxt = mtm_pkg::ST_PROD;
            cnt_nxt   = '0;
          end
        end
      end
      mtm_pkg::ST_PROD: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd7) begin
          state_nxt = mtm_pkg::ST_ELEM;
          cnt_nxt   = '0;
        end
      end
      mtm_pkg::ST_ELEM: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd8) begin
          state_nxt = mtm_pkg::ST_OUT;
          cnt_nxt   = '0;
        end
      end
      mtm_pkg::ST_OUT: begin
        if (out_valid && out_ready) cnt_nxt = cnt_r + 5'd1;
        if (emit_done) state_nxt = mtm_pkg::ST_IDLE;
      end
      default: state_nxt = mtm_pkg::ST_IDLE;
    endcase
  end

  // CORDIC shift-add unit
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic signed [33:0] ch_nxt_x, ch_nxt_y, ch_nxt_z;
  logic [ANGLE_BITS-1:0] cur_ang;
  logic signed [33:0] cur_c, cur_s;
  logic signed [33:0] cosv_r [3];
  logic signed [33:0] sinv_r [3];

  assign cur_ang = angle_r[ax_r];

  always_comb begin
    logic signed [33:0] x0, y0, z0;
    logic signed [33:0] atn;
    if (it_r == '0) begin
      x0 = mtm_pkg::CORDIC_GAIN;
      y0 = '0;
      z0 = 34'({cur_ang[ANGLE_BITS-3:0]}) <<< (32 - ANGLE_BITS);
    end else begin
      x0 = cx_r;
      y0 = cy_r;
      z0 = cz_r;
    end
    atn = 34'(mtm_pkg::atan_turn(5'(it_r)));
    if (!z0[33]) begin
      ch_nxt_x = x0 - (y0 >>> it_r);
      ch_nxt_y = y0 + (x0 >>> it_r);
      ch_nxt_z = z0 - atn;
    end else begin
      ch_nxt_x = x0 + (y0 >>> it_r);
      ch_nxt_y = y0 - (x0 >>> it_r);
      ch_nxt_z = z0 + atn;
    end
    unique case (cur_ang[ANGLE_BITS-1 -: 2])
      2'd0: begin cur_c = ch_nxt_x;  cur_s = ch_nxt_y;  end
      2'd1: begin cur_c = -ch_nxt_y; cur_s = ch_nxt_x;  end
      2'd2: begin cur_c = -ch_nxt_x; cur_s = -ch_nxt_y; end
      default: begin cur_c = ch_nxt_y; cur_s = -ch_nxt_x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == mtm_pkg::ST_TRIG) begin
      cx_r <= ch_nxt_x;
      cy_r <= ch_nxt_y;
      cz_r <= ch_nxt_z;
      if (it_r == IT_LAST) begin
        cosv_r[ax_r] <= cur_c;
        sinv_r[ax_r] <= cur_s;
      end
    end
  end

  // shared multiplier: round(a*b / 2^30)
  logic signed [33:0] ma, mb;
  logic signed [67:0] mprod;
  logic signed [35:0] mres;
  assign mprod = 68'(ma) * 68'(mb) + 68'sd536870912;
  assign mres  = 36'(mprod >>> 30);

  // product schedule (Q2.30 terms)
  logic signed [35:0] czsy_r, szsy_r, t_r;
  logic signed [35:0] rot_r [9];

  // element operands picked by the element counter
  logic [1:0]          orow, ocol;
  logic signed [35:0]  ea;
  logic signed [31:0]  eb;

  assign orow = cnt_r[3:2];
  assign ocol = cnt_r[1:0];

  always_comb begin
    ea = rot_r[(orow == 2'd3 ? 4'd0 : 4'(orow) * 4'd3) +
               (ocol == 2'd3 ? 4'd0 : 4'(ocol))];
    eb = stretch_r[ocol == 2'd3 ? 2'd0 : ocol];
  end

  always_comb begin
    ma = '0;
    mb = '0;
    if (state_r == mtm_pkg::ST_PROD) begin
      unique case (cnt_r[2:0])
        3'd0: begin ma = cosv_r[2]; mb = sinv_r[1]; end
        3'd1: begin ma = sinv_r[2]; mb = sinv_r[1]; end
        3'd2: begin ma = cosv_r[2]; mb = cosv_r[1]; end
        3'd3: begin ma = sinv_r[2]; mb = cosv_r[1]; end
        3'd4: begin ma = cosv_r[1]; mb = sinv_r[0]; end
        3'd5: begin ma = cosv_r[1]; mb = cosv_r[0]; end
        3'd6: begin ma = sinv_r[2]; mb = cosv_r[0]; end
        default: begin ma = czsy_r[33:0]; mb = sinv_r[0]; end
      endcase
    end else if (state_r == mtm_pkg::ST_ELEM) begin
      unique case (cnt_r[3:0])
        4'd0: begin ma = czsy_r[33:0]; mb = cosv_r[0]; end
        4'd1: begin ma = sinv_r[2];    mb = sinv_r[0]; end
        4'd2: begin ma = szsy_r[33:0]; mb = sinv_r[0]; end
        4'd3: begin ma = cosv_r[2];    mb = cosv_r[0]; end
        4'd4: begin ma = szsy_r[33:0]; mb = cosv_r[0]; end
        4'd5: begin ma = cosv_r[2];    mb = sinv_r[0]; end
        default: ;
      endcase
    end else if (state_r == mtm_pkg::ST_OUT) begin
      ma = ea[33:0];
      mb = 34'(eb);
    end
  end

  // PROD forms the first products; in ELEM cnt 0..5 finish the rotation terms, 6..8 are spare
  always_ff @(posedge clk) begin
    if (state_r == mtm_pkg::ST_PROD) begin
      unique case (cnt_r[2:0])
        3'd0: czsy_r <= mres;
        3'd1: szsy_r <= mres;
        3'd2: rot_r[0] <= mres;
        3'd3: rot_r[3] <= mres;
        3'd4: rot_r[7] <= mres;
        3'd5: rot_r[8] <= mres;
        3'd6: t_r <= mres;
        default: rot_r[1] <= mres - t_r;
      endcase
      rot_r[6] <= -36'(sinv_r[1]);
    end else if (state_r == mtm_pkg::ST_ELEM) begin
      unique case (cnt_r[3:0])
        4'd0: t_r <= mres;
        4'd1: rot_r[2] <= t_r + mres;
        4'd2: t_r <= mres;
        4'd3: rot_r[4] <= t_r + mres;
        4'd4: t_r <= mres;
        4'd5: rot_r[5] <= t_r - mres;
        default: ;
      endcase
    end
  end

  // output: element value from the shared multiplier, an offset or a constant
  logic signed [31:0]  evalue;
  logic out_pend_r;
  logic signed [31:0] oval_r;
  logic [3:0] ocnt_r;

  always_comb begin
    if (orow == 2'd3)
      evalue = (ocol == 2'd3) ? ONE_FX[31:0] : 32'sd0;
    else if (ocol == 2'd3)
      evalue = offset_r[orow];
    else if (mres > 36'sd2147483647)
      evalue = 32'sh7fffffff;
    else if (mres < -36'sd2147483648)
      evalue = 32'sh80000000;
    else
      evalue = mres[31:0];
  end

  // output register: loaded when empty, holds under stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_pend_r <= 1'b0;
    end else if (state_r == mtm_pkg::ST_OUT && !out_pend_r) begin
      out_pend_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mtm_pkg::ST_OUT && !out_pend_r) begin
      oval_r <= evalue;
      ocnt_r <= cnt_r[3:0];
    end
  end

  assign out_valid      = out_pend_r;
  assign out_data.row   = ocnt_r[3:2];
  assign out_data.col   = ocnt_r[1:0];
  assign out_data.value = oval_r;
  assign out_data.last  = (ocnt_r == 4'd15);

  // assertions
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("in_ready while emitting");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_done |=> in_ready) else $error("not idle after last element");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(oval_r)))
    else $error("output changed under stall");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for model_transform_matrix: events go in on a
// valid/ready channel, each expands to 16 matrix elements that are compared
// against a cycle-free predictor of position, rotation, scale and CORDIC trig.
// ----------------------------------------------------------------------------
module tb;

  localparam int      LATENCY     = 120;
  localparam logic [31:0] ONE_FX  = 32'sd65536;
  localparam longint  SCALE_FLOOR = (65536 + 50) / 100;
  localparam longint  HALF30      = 64'sd1 << 29;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mtm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mtm_pkg::out_item_t out_data;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  model_transform_matrix DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // predictor state
  logic [16:0] move_step;
  logic [14:0] turn_step;
  logic [16:0] grow_step;
  logic signed [31:0] offs [3];
  logic [15:0] ang [3];
  logic signed [31:0] strch [3];
  mtm_pkg::out_item_t elem_q [$];
  int errors = 0;
  bit hold_off = 0;

  function automatic longint asr_f(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint prod30(longint a, longint b);
    return (a * b + HALF30) >>> 30;
  endfunction

  task automatic cordic(input logic [15:0] ph, output longint c, output longint s);
    longint x, y, z, nx;
    x = mtm_pkg::CORDIC_GAIN;
    y = 0;
    z = longint'(ph[13:0]) << 16;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - asr_f(y, i); y = y + asr_f(x, i);
        z -= longint'(mtm_pkg::atan_turn(5'(i)));
      end else begin
        nx = x + asr_f(y, i); y = y - asr_f(x, i);
        z += longint'(mtm_pkg::atan_turn(5'(i)));
      end
      x = nx;
    end
    case (ph[15:14])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic clear_pose();
    for (int i = 0; i < 3; i++) begin
      offs[i] = 0; ang[i] = 0; strch[i] = ONE_FX;
    end
  endtask

  task automatic predict_matrix(input mtm_pkg::in_item_t it);
    longint cx, sx, cy, sy, cz, sz, czsy, szsy, v;
    longint rot [3][3];
    mtm_pkg::out_item_t e;
    int a;
    a = it.axis;
    if (it.action == mtm_pkg::ACT_RESET) clear_pose();
    else if (a < 3) begin
      case (it.action)
        mtm_pkg::ACT_MOVE: offs[a] = clip32(longint'(offs[a]) +
                                   (it.upward ? longint'(move_step) : -longint'(move_step)));
        mtm_pkg::ACT_ROTATE: ang[a] = it.upward ? ang[a] + turn_step : ang[a] - turn_step;
        mtm_pkg::ACT_SCALE: begin
          v = clip32(longint'(strch[a]) +
                     (it.upward ? longint'(grow_step) : -longint'(grow_step)));
          if (v < SCALE_FLOOR) v = SCALE_FLOOR;
          strch[a] = v[31:0];
        end
        default: ;
      endcase
    end
    cordic(ang[0], cx, sx);
    cordic(ang[1], cy, sy);
    cordic(ang[2], cz, sz);
    czsy = prod30(cz, sy);
    szsy = prod30(sz, sy);
    rot[0][0] = prod30(cz, cy);
    rot[0][1] = prod30(czsy, sx) - prod30(sz, cx);
    rot[0][2] = prod30(czsy, cx) + prod30(sz, sx);
    rot[1][0] = prod30(sz, cy);
    rot[1][1] = prod30(szsy, sx) + prod30(cz, cx);
    rot[1][2] = prod30(szsy, cx) - prod30(cz, sx);
    rot[2][0] = -sy;
    rot[2][1] = prod30(cy, sx);
    rot[2][2] = prod30(cy, cx);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        e.row = 2'(i); e.col = 2'(j); e.last = (i == 3 && j == 3);
        if (i == 3) e.value = (j == 3) ? ONE_FX : 0;
        else if (j == 3) e.value = offs[i];
        else e.value = clip32(prod30(rot[i][j], longint'(strch[j])));
        elem_q.push_back(e);
      end
  endtask

  task automatic report(input string what);
    errors++;
    $display("%0t error: %s", $realtime, what);
  endtask

  // receiver
  int stall_mode = 0;
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
    if (rst_n && out_valid && out_ready) begin
      if (elem_q.size() == 0) report("element with nothing expected");
      else begin
        mtm_pkg::out_item_t e;
        e = elem_q.pop_front();
        if (out_data.row !== e.row || out_data.col !== e.col)
          report($sformatf("position %0d,%0d want %0d,%0d",
                 out_data.row, out_data.col, e.row, e.col));
        if (out_data.value !== e.value)
          report($sformatf("[%0d][%0d] value %0d want %0d",
                 e.row, e.col, out_data.value, e.value));
        if (out_data.last !== e.last) report("last flag");
      end
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic send(input mtm_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_matrix(it);
  endtask

  task automatic idle_in();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (elem_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic reg_write(input mtm_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val; cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      mtm_pkg::REG_MOVE: move_step = val[16:0];
      mtm_pkg::REG_TURN: turn_step = val[14:0];
      default:           grow_step = val[16:0];
    endcase
  endtask

  task automatic set_steps(input logic [16:0] m, input logic [14:0] t, input logic [16:0] g);
    reg_write(mtm_pkg::REG_MOVE, {15'd0, m});
    reg_write(mtm_pkg::REG_TURN, {17'd0, t});
    reg_write(mtm_pkg::REG_GROW, {15'd0, g});
  endtask

  function automatic mtm_pkg::in_item_t mk(input logic [2:0] a, input logic [1:0] x,
                                           input logic u);
    mtm_pkg::in_item_t it;
    it.action = a; it.axis = x; it.upward = u;
    return it;
  endfunction

  typedef struct {
    mtm_pkg::in_item_t it;
    bit       check_val;
    logic [1:0] row, col;
    logic signed [31:0] val;
  } stim_row_t;

  stim_row_t plan [$];

  task automatic random_item(output mtm_pkg::in_item_t it);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)       it.action = mtm_pkg::ACT_RESET;
    else if (r < 30) it.action = mtm_pkg::ACT_MOVE;
    else if (r < 60) it.action = mtm_pkg::ACT_ROTATE;
    else if (r < 90) it.action = mtm_pkg::ACT_SCALE;
    else             it.action = 3'($urandom_range(4, 7));
    it.axis = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    it.upward = 1'($urandom_range(0, 1));
  endtask

  task automatic random_phase(input int n);
    mtm_pkg::in_item_t it;
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        if (n > 0) begin
          random_item(it);
          send(it);
          n--;
        end
      end
      repeat ($urandom_range(0, 3) * $urandom_range(0, 40)) idle_in();
    end
  endtask

  initial begin
    mtm_pkg::in_item_t it;
    move_step = mtm_pkg::MOVE_STEP_RST;
    turn_step = mtm_pkg::TURN_STEP_RST;
    grow_step = mtm_pkg::GROW_STEP_RST;
    clear_pose();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; typed values only where obvious
    plan.push_back('{mk(mtm_pkg::ACT_EMIT, 0, 0), 1, 3, 3, ONE_FX});
    plan.push_back('{mk(mtm_pkg::ACT_MOVE, 0, 1), 1, 0, 3, 32'sd6554});
    plan.push_back('{mk(mtm_pkg::ACT_MOVE, 1, 0), 1, 1, 3, -32'sd6554});
    plan.push_back('{mk(mtm_pkg::ACT_MOVE, 2, 1), 1, 2, 3, 32'sd6554});
    plan.push_back('{mk(mtm_pkg::ACT_ROTATE, 0, 1), 0, 0, 0, 0});
    plan.push_back('{mk(mtm_pkg::ACT_ROTATE, 1, 0), 0, 0, 0, 0});
    plan.push_back('{mk(mtm_pkg::ACT_ROTATE, 2, 1), 0, 0, 0, 0});
    plan.push_back('{mk(mtm_pkg::ACT_SCALE, 0, 1), 0, 0, 0, 0});
    plan.push_back('{mk(mtm_pkg::ACT_SCALE, 1, 0), 0, 0, 0, 0});
    plan.push_back('{mk(mtm_pkg::ACT_SCALE, 2, 1), 0, 0, 0, 0});
    plan.push_back('{mk(mtm_pkg::ACT_MOVE, 3, 1), 0, 0, 0, 0});
    plan.push_back('{mk(mtm_pkg::ACT_SCALE, 3, 0), 0, 0, 0, 0});
    plan.push_back('{mk(3'd5, 0, 1), 0, 0, 0, 0});
    plan.push_back('{mk(3'd6, 1, 0), 0, 0, 0, 0});
    plan.push_back('{mk(3'd7, 2, 1), 0, 0, 0, 0});
    plan.push_back('{mk(mtm_pkg::ACT_RESET, 3, 1), 1, 3, 3, ONE_FX});
    foreach (plan[k]) begin
      int base;
      send(plan[k].it);
      base = elem_q.size() - 16;
      if (plan[k].check_val &&
          elem_q[base + plan[k].row * 4 + plan[k].col].value !== plan[k].val)
        report($sformatf("directed row %0d predictor disagrees with table", k));
    end
    drain();

    // scale floor at extreme steps
    set_steps(17'd65536, 15'd32767, 17'd65536);
    repeat (3) send(mk(mtm_pkg::ACT_SCALE, 0, 0));
    repeat (3) send(mk(mtm_pkg::ACT_ROTATE, 1, 1));
    drain();
    set_steps(17'd65536, 15'd0, 17'd0);
    send(mk(mtm_pkg::ACT_SCALE, 1, 1));
    send(mk(mtm_pkg::ACT_ROTATE, 2, 1));
    // let the block back up while the receiver holds off
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (4) send(mk(mtm_pkg::ACT_MOVE, 0, 1));
    join
    drain();

    // random phases across several step settings
    set_steps(mtm_pkg::MOVE_STEP_RST, mtm_pkg::TURN_STEP_RST, mtm_pkg::GROW_STEP_RST);
    random_phase(70);
    drain();
    set_steps(17'd65536, 15'd16384, 17'd1);
    random_phase(60);
    drain();
    set_steps(17'd0, 15'd1, 17'd65536);
    random_phase(50);
    drain();
    set_steps(17'($urandom_range(0, 65536)), 15'($urandom_range(0, 32767)),
              17'($urandom_range(0, 65536)));
    random_phase(70);
    // big moves on one axis, alternating down and up
    drain();
    set_steps(17'd65536, 15'd12345, 17'd65536);
    for (int k = 0; k < 6; k++) begin
      it = mk(mtm_pkg::ACT_MOVE, 2, k[0]);
      send(it);
    end
    drain();

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
rtl/mtm_pkg.sv
rtl/model_transform_matrix.sv
tb/tb.sv
